// ----- src/bpid_pkg.sv -----
`default_nettype none

package bpid_pkg;

    localparam int unsigned RAW_W    = 16;
    localparam int unsigned TEMP_W   = 13;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned DUTY_W   = 16;
    localparam int unsigned MS_W     = 10;
    localparam int unsigned LIMIT_W  = 8;
    localparam int unsigned ERR_W    = 14;
    localparam int unsigned DERR_W   = 15;
    localparam int unsigned ISUM_W   = 40;
    localparam int unsigned ACC_W    = 42;
    localparam int unsigned FRAC_W   = 10;
    localparam int unsigned MUL_W    = 17;
    localparam int unsigned PROD_W   = 2 * MUL_W;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam int unsigned PERIOD_MS_DEF = 1000;
    localparam int unsigned PERIOD_W      = 16;

    localparam int unsigned DIV_STEPS = DUTY_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [ISUM_W-1:0] ISUM_MAX = {1'b0, {(ISUM_W-1){1'b1}}};
    localparam logic [ISUM_W-1:0] ISUM_MIN = {1'b1, {(ISUM_W-1){1'b0}}};

    localparam logic [TEMP_W-1:0]  RST_TARGET = 13'd380;
    localparam logic [GAIN_W-1:0]  RST_GAIN_P = 16'd256;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I = 16'd0;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D = 16'd0;
    localparam logic [DUTY_W-1:0]  RST_MAX    = 16'd100;
    localparam logic [LIMIT_W-1:0] RST_LIMIT  = 8'd10;
    localparam logic [TEMP_W-1:0]  RST_FLOOR  = 13'd40;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_SENSOR   = 2'd1,
        MODE_OVERHEAT = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 3'd0,
        CFG_GAIN_P = 3'd1,
        CFG_GAIN_I = 3'd2,
        CFG_GAIN_D = 3'd3,
        CFG_MAX    = 3'd4,
        CFG_LIMIT  = 3'd5,
        CFG_FLOOR  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [TEMP_W-1:0]  target_temp;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [DUTY_W-1:0]  max_duty;
        logic [LIMIT_W-1:0] overheat_limit;
        logic [TEMP_W-1:0]  sensor_floor;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_MUL_P,
        OP_MUL_I,
        OP_INTEG,
        OP_MUL_D,
        OP_ADD_D,
        OP_CLAMP,
        OP_MUL_T,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_DIV,
        HOLD_OUT
    } t_hold;

    localparam int unsigned PC_W = 4;

    localparam logic [PC_W-1:0] STEP_LOAD     = 4'd0;
    localparam logic [PC_W-1:0] STEP_MUL_P    = 4'd1;
    localparam logic [PC_W-1:0] STEP_MUL_I    = 4'd2;
    localparam logic [PC_W-1:0] STEP_INTEG    = 4'd3;
    localparam logic [PC_W-1:0] STEP_MUL_D    = 4'd4;
    localparam logic [PC_W-1:0] STEP_ADD_D    = 4'd5;
    localparam logic [PC_W-1:0] STEP_CLAMP    = 4'd6;
    localparam logic [PC_W-1:0] STEP_MUL_T    = 4'd7;
    localparam logic [PC_W-1:0] STEP_DIV_INIT = 4'd8;
    localparam logic [PC_W-1:0] STEP_DIV      = 4'd9;
    localparam logic [PC_W-1:0] STEP_FINISH   = 4'd10;
    localparam logic [PC_W-1:0] STEP_LAST     = STEP_FINISH;

    typedef struct packed {
        t_op             op;
        t_hold           hold;
        logic            jump;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctrl;

    typedef struct packed {
        logic div_last;
        logic out_busy;
    } t_stat;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_LOAD, hold: HOLD_IN, jump: 1'b1, target: STEP_LOAD};
        case (pc)
            STEP_LOAD:     w = '{OP_LOAD,     HOLD_IN,   1'b0, STEP_LOAD};
            STEP_MUL_P:    w = '{OP_MUL_P,    HOLD_NONE, 1'b0, STEP_LOAD};
            STEP_MUL_I:    w = '{OP_MUL_I,    HOLD_NONE, 1'b0, STEP_LOAD};
            STEP_INTEG:    w = '{OP_INTEG,    HOLD_NONE, 1'b0, STEP_LOAD};
            STEP_MUL_D:    w = '{OP_MUL_D,    HOLD_NONE, 1'b0, STEP_LOAD};
            STEP_ADD_D:    w = '{OP_ADD_D,    HOLD_NONE, 1'b0, STEP_LOAD};
            STEP_CLAMP:    w = '{OP_CLAMP,    HOLD_NONE, 1'b0, STEP_LOAD};
            STEP_MUL_T:    w = '{OP_MUL_T,    HOLD_NONE, 1'b0, STEP_LOAD};
            STEP_DIV_INIT: w = '{OP_DIV_INIT, HOLD_NONE, 1'b0, STEP_LOAD};
            STEP_DIV:      w = '{OP_DIV_STEP, HOLD_DIV,  1'b0, STEP_LOAD};
            STEP_FINISH:   w = '{OP_FINISH,   HOLD_OUT,  1'b1, STEP_LOAD};
            default:       w = '{OP_LOAD,     HOLD_NONE, 1'b1, STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- src/bpid_in_if.sv -----
`default_nettype none

interface bpid_in_if;
    logic                            valid;
    logic                            ready;
    logic [bpid_pkg::RAW_W-1:0]      raw_word;

    modport source (output valid, output raw_word, input ready);
    modport sink   (input valid, input raw_word, output ready);
endinterface

`default_nettype wire

// ----- src/bpid_out_if.sv -----
`default_nettype none

interface bpid_out_if;
    logic                            valid;
    logic                            ready;
    logic [bpid_pkg::DUTY_W-1:0]     duty;
    logic [bpid_pkg::MS_W-1:0]       on_ms;
    logic [bpid_pkg::MS_W-1:0]       off_ms;
    logic [1:0]                      fault_mode;
    logic [bpid_pkg::TEMP_W-1:0]     temperature;

    modport source (output valid, output duty, output on_ms, output off_ms,
                    output fault_mode, output temperature, input ready);
    modport sink   (input valid, input duty, input on_ms, input off_ms,
                    input fault_mode, input temperature, output ready);
endinterface

`default_nettype wire

// ----- src/bpid_cfg_if.sv -----
`default_nettype none

interface bpid_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bpid_pkg::CFG_IDX_W-1:0]     index;
    logic [bpid_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/boiler_pid_duty_controller.sv -----
`default_nettype none

// Channel   Port    Direction  Payload
// input     i_in    sink       raw_word
// result    o_out   source     duty, on_ms, off_ms, fault_mode, temperature
// config    i_cfg   sink       index, data (always ready)
//
// A result is registered after its input beat has run through the microcode,
// and the next input beat is taken only after that: ten microcode steps plus
// a restoring division of duty times the period by max_duty.
// Reset is synchronous and active low; it restores the register defaults and
// clears the controller state. A result waits in its output register while the
// next item is accepted; that item stalls only at its last step.

module boiler_pid_duty_controller #(
    parameter int unsigned PERIOD_MS = bpid_pkg::PERIOD_MS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    bpid_in_if.sink         i_in,
    bpid_out_if.source      o_out,
    bpid_cfg_if.sink        i_cfg
);

    bpid_pkg::t_cfg  r_cfg;
    bpid_pkg::t_cfg  n_cfg;
    bpid_pkg::t_ctrl ctrl;
    bpid_pkg::t_stat stat;
    logic            in_ready;
    logic [1:0]      fault_mode;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                bpid_pkg::CFG_TARGET: n_cfg.target_temp    = i_cfg.data[bpid_pkg::TEMP_W-1:0];
                bpid_pkg::CFG_GAIN_P: n_cfg.gain_p         = i_cfg.data;
                bpid_pkg::CFG_GAIN_I: n_cfg.gain_i         = i_cfg.data;
                bpid_pkg::CFG_GAIN_D: n_cfg.gain_d         = i_cfg.data;
                bpid_pkg::CFG_MAX:    n_cfg.max_duty       = i_cfg.data;
                bpid_pkg::CFG_LIMIT:  n_cfg.overheat_limit = i_cfg.data[bpid_pkg::LIMIT_W-1:0];
                bpid_pkg::CFG_FLOOR:  n_cfg.sensor_floor   = i_cfg.data[bpid_pkg::TEMP_W-1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_temp    <= bpid_pkg::RST_TARGET;
            r_cfg.gain_p         <= bpid_pkg::RST_GAIN_P;
            r_cfg.gain_i         <= bpid_pkg::RST_GAIN_I;
            r_cfg.gain_d         <= bpid_pkg::RST_GAIN_D;
            r_cfg.max_duty       <= bpid_pkg::RST_MAX;
            r_cfg.overheat_limit <= bpid_pkg::RST_LIMIT;
            r_cfg.sensor_floor   <= bpid_pkg::RST_FLOOR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    bpid_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_ctrl     (ctrl)
    );

    bpid_dp #(
        .PERIOD_MS (PERIOD_MS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_ctrl        (ctrl),
        .i_raw_word    (i_in.raw_word),
        .i_out_ready   (o_out.ready),
        .o_stat        (stat),
        .o_valid       (o_out.valid),
        .o_duty        (o_out.duty),
        .o_on_ms       (o_out.on_ms),
        .o_off_ms      (o_out.off_ms),
        .o_fault_mode  (fault_mode),
        .o_temperature (o_out.temperature)
    );

    assign i_in.ready       = in_ready;
    assign o_out.fault_mode = fault_mode;

endmodule

`default_nettype wire

// ----- src/bpid_seq.sv -----
`default_nettype none

module bpid_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire bpid_pkg::t_stat i_stat,
    output logic                 o_in_ready,
    output bpid_pkg::t_ctrl      o_ctrl
);

    logic [bpid_pkg::PC_W-1:0] r_pc;
    logic [bpid_pkg::PC_W-1:0] n_pc;
    bpid_pkg::t_uword          uw;
    logic                      fire;
    logic                      advance;

    always_comb begin
        uw         = bpid_pkg::ucode(r_pc);
        o_in_ready = (uw.hold == bpid_pkg::HOLD_IN);
        case (uw.hold)
            bpid_pkg::HOLD_IN:  fire = i_in_valid;
            bpid_pkg::HOLD_OUT: fire = !i_stat.out_busy;
            default:            fire = 1'b1;
        endcase
        advance = (uw.hold == bpid_pkg::HOLD_DIV) ? i_stat.div_last : fire;
        if (!advance) begin
            n_pc = r_pc;
        end else if (uw.jump) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
        o_ctrl.op   = uw.op;
        o_ctrl.fire = fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= bpid_pkg::STEP_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    a_finish_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.fire && o_ctrl.op == bpid_pkg::OP_FINISH) |=> r_pc == bpid_pkg::STEP_LOAD)
        else $error("sequencer did not return to the load step after a result");

endmodule

`default_nettype wire

// ----- src/bpid_dp.sv -----
`default_nettype none

module bpid_dp #(
    parameter int unsigned PERIOD_MS = bpid_pkg::PERIOD_MS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bpid_pkg::t_cfg                i_cfg,
    input  wire bpid_pkg::t_ctrl               i_ctrl,
    input  wire logic [bpid_pkg::RAW_W-1:0]    i_raw_word,
    input  wire logic                          i_out_ready,
    output bpid_pkg::t_stat                    o_stat,
    output logic                               o_valid,
    output logic [bpid_pkg::DUTY_W-1:0]        o_duty,
    output logic [bpid_pkg::MS_W-1:0]          o_on_ms,
    output logic [bpid_pkg::MS_W-1:0]          o_off_ms,
    output logic [1:0]                         o_fault_mode,
    output logic [bpid_pkg::TEMP_W-1:0]        o_temperature
);

    localparam logic [bpid_pkg::PERIOD_W-1:0] PERIOD_V = bpid_pkg::PERIOD_W'(PERIOD_MS);
    localparam int unsigned CEIL_W = bpid_pkg::DUTY_W + bpid_pkg::FRAC_W;

    logic [bpid_pkg::TEMP_W-1:0]          r_temp, n_temp;
    logic signed [bpid_pkg::ERR_W-1:0]    r_err, n_err;
    logic signed [bpid_pkg::DERR_W-1:0]   r_derr, n_derr;
    logic signed [bpid_pkg::ERR_W-1:0]    r_prev, n_prev;
    logic signed [bpid_pkg::ISUM_W-1:0]   r_isum, n_isum;
    logic [bpid_pkg::LIMIT_W-1:0]         r_cnt, n_cnt;
    bpid_pkg::t_mode                      r_mode, n_mode;
    logic signed [bpid_pkg::PROD_W-1:0]   r_prod, n_prod;
    logic                                 r_gate, n_gate;
    logic signed [bpid_pkg::ACC_W-1:0]    r_acc, n_acc;
    logic [bpid_pkg::DUTY_W-1:0]          r_duty, n_duty;
    logic [bpid_pkg::DUTY_W-1:0]          r_rem, n_rem;
    logic [bpid_pkg::DUTY_W-1:0]          r_quo, n_quo;
    logic [bpid_pkg::DIV_CNT_W-1:0]       r_div_cnt, n_div_cnt;
    logic                                 r_out_valid, n_out_valid;
    logic [bpid_pkg::DUTY_W-1:0]          r_o_duty, n_o_duty;
    logic [bpid_pkg::MS_W-1:0]            r_o_on, n_o_on;
    logic [bpid_pkg::MS_W-1:0]            r_o_off, n_o_off;
    bpid_pkg::t_mode                      r_o_mode, n_o_mode;
    logic [bpid_pkg::TEMP_W-1:0]          r_o_temp, n_o_temp;

    logic [bpid_pkg::TEMP_W-1:0]          raw_temp;
    logic [bpid_pkg::ERR_W-1:0]           raw_err;
    logic [bpid_pkg::LIMIT_W-1:0]         cnt_dec;
    logic signed [bpid_pkg::MUL_W-1:0]    mul_a, mul_b;
    logic signed [bpid_pkg::PROD_W-1:0]   mul_p;
    logic [bpid_pkg::ISUM_W:0]            isum_add;
    logic [CEIL_W-1:0]                    ceil_v;
    logic [CEIL_W-1:0]                    clamp_v;
    logic [bpid_pkg::DUTY_W:0]            trial;
    logic [bpid_pkg::DUTY_W-1:0]          quo_v;
    logic [bpid_pkg::PERIOD_W-1:0]        off_v;

    always_comb begin
        raw_temp = i_raw_word[bpid_pkg::RAW_W-1:bpid_pkg::RAW_W-bpid_pkg::TEMP_W];
        raw_err  = bpid_pkg::ERR_W'({1'b0, i_cfg.target_temp} - {1'b0, raw_temp});
        ceil_v   = {i_cfg.max_duty, {bpid_pkg::FRAC_W{1'b0}}};
        isum_add = {r_isum[bpid_pkg::ISUM_W-1], r_isum}
                 + {{(bpid_pkg::ISUM_W+1-bpid_pkg::PROD_W){r_prod[bpid_pkg::PROD_W-1]}}, r_prod};
        trial    = {r_rem, r_quo[bpid_pkg::DUTY_W-1]};
        quo_v    = (i_cfg.max_duty == '0) ? '0 : r_quo;
        off_v    = PERIOD_V - quo_v;
        cnt_dec  = (r_cnt != '0) ? r_cnt - 1'b1 : r_cnt;

        if (r_acc[bpid_pkg::ACC_W-1]) begin
            clamp_v = '0;
        end else if ($unsigned(r_acc) > {{(bpid_pkg::ACC_W-CEIL_W){1'b0}}, ceil_v}) begin
            clamp_v = ceil_v;
        end else begin
            clamp_v = r_acc[CEIL_W-1:0];
        end

        mul_a = '0;
        mul_b = '0;
        case (i_ctrl.op)
            bpid_pkg::OP_MUL_P: begin
                mul_a = {1'b0, i_cfg.gain_p};
                mul_b = {{(bpid_pkg::MUL_W-bpid_pkg::ERR_W){r_err[bpid_pkg::ERR_W-1]}}, r_err};
            end
            bpid_pkg::OP_MUL_I: begin
                mul_a = {1'b0, i_cfg.gain_i};
                mul_b = {{(bpid_pkg::MUL_W-bpid_pkg::ERR_W){r_err[bpid_pkg::ERR_W-1]}}, r_err};
            end
            bpid_pkg::OP_MUL_D: begin
                mul_a = {1'b0, i_cfg.gain_d};
                mul_b = {{(bpid_pkg::MUL_W-bpid_pkg::DERR_W){r_derr[bpid_pkg::DERR_W-1]}},
                         r_derr};
            end
            bpid_pkg::OP_MUL_T: begin
                mul_a = {1'b0, r_duty};
                mul_b = {1'b0, PERIOD_V};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;

        n_temp      = r_temp;
        n_err       = r_err;
        n_derr      = r_derr;
        n_prev      = r_prev;
        n_isum      = r_isum;
        n_cnt       = r_cnt;
        n_mode      = r_mode;
        n_prod      = r_prod;
        n_gate      = r_gate;
        n_acc       = r_acc;
        n_duty      = r_duty;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_duty    = r_o_duty;
        n_o_on      = r_o_on;
        n_o_off     = r_o_off;
        n_o_mode    = r_o_mode;
        n_o_temp    = r_o_temp;

        if (i_ctrl.fire) begin
            case (i_ctrl.op)
                bpid_pkg::OP_LOAD: begin
                    n_temp = raw_temp;
                    if (raw_temp < i_cfg.sensor_floor) begin
                        n_mode = bpid_pkg::MODE_SENSOR;
                    end
                    if (raw_temp > i_cfg.target_temp) begin
                        if (r_cnt > i_cfg.overheat_limit) begin
                            n_mode = bpid_pkg::MODE_OVERHEAT;
                        end else if (r_cnt != '1) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else if (n_mode == bpid_pkg::MODE_OVERHEAT) begin
                        n_cnt = cnt_dec;
                        if (cnt_dec == '0) begin
                            n_mode = bpid_pkg::MODE_NORMAL;
                        end
                    end
                    n_err  = raw_err;
                    n_derr = {raw_err[bpid_pkg::ERR_W-1], raw_err}
                           - {r_prev[bpid_pkg::ERR_W-1], r_prev};
                    n_prev = raw_err;
                end
                bpid_pkg::OP_MUL_P: begin
                    n_prod = mul_p;
                    n_gate = r_isum < $signed({{(bpid_pkg::ISUM_W-CEIL_W){1'b0}}, ceil_v});
                end
                bpid_pkg::OP_MUL_I: begin
                    n_acc  = {{(bpid_pkg::ACC_W-bpid_pkg::PROD_W){r_prod[bpid_pkg::PROD_W-1]}},
                              r_prod};
                    n_prod = mul_p;
                end
                bpid_pkg::OP_INTEG: begin
                    if (r_gate) begin
                        if (isum_add[bpid_pkg::ISUM_W] != isum_add[bpid_pkg::ISUM_W-1]) begin
                            n_isum = isum_add[bpid_pkg::ISUM_W] ? bpid_pkg::ISUM_MIN
                                                                : bpid_pkg::ISUM_MAX;
                        end else begin
                            n_isum = isum_add[bpid_pkg::ISUM_W-1:0];
                        end
                    end
                end
                bpid_pkg::OP_MUL_D: begin
                    n_acc  = r_acc
                           + {{(bpid_pkg::ACC_W-bpid_pkg::ISUM_W){r_isum[bpid_pkg::ISUM_W-1]}},
                              r_isum};
                    n_prod = mul_p;
                end
                bpid_pkg::OP_ADD_D: begin
                    n_acc = r_acc
                          + {{(bpid_pkg::ACC_W-bpid_pkg::PROD_W){r_prod[bpid_pkg::PROD_W-1]}},
                             r_prod};
                end
                bpid_pkg::OP_CLAMP: begin
                    if (r_mode == bpid_pkg::MODE_NORMAL) begin
                        n_duty = clamp_v[CEIL_W-1:bpid_pkg::FRAC_W];
                    end else begin
                        n_duty = '0;
                    end
                end
                bpid_pkg::OP_MUL_T: begin
                    n_prod = mul_p;
                end
                bpid_pkg::OP_DIV_INIT: begin
                    n_rem     = r_prod[2*bpid_pkg::DUTY_W-1:bpid_pkg::DUTY_W];
                    n_quo     = r_prod[bpid_pkg::DUTY_W-1:0];
                    n_div_cnt = '0;
                end
                bpid_pkg::OP_DIV_STEP: begin
                    if (trial >= {1'b0, i_cfg.max_duty}) begin
                        n_rem = bpid_pkg::DUTY_W'(trial - {1'b0, i_cfg.max_duty});
                        n_quo = {r_quo[bpid_pkg::DUTY_W-2:0], 1'b1};
                    end else begin
                        n_rem = trial[bpid_pkg::DUTY_W-1:0];
                        n_quo = {r_quo[bpid_pkg::DUTY_W-2:0], 1'b0};
                    end
                    n_div_cnt = r_div_cnt + 1'b1;
                end
                bpid_pkg::OP_FINISH: begin
                    n_o_duty    = r_duty;
                    n_o_on      = quo_v[bpid_pkg::MS_W-1:0];
                    n_o_off     = off_v[bpid_pkg::MS_W-1:0];
                    n_o_mode    = r_mode;
                    n_o_temp    = r_temp;
                    n_out_valid = 1'b1;
                end
                default: begin
                    n_out_valid = r_out_valid && !i_out_ready;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_isum      <= '0;
            r_cnt       <= '0;
            r_mode      <= bpid_pkg::MODE_NORMAL;
            r_out_valid <= 1'b0;
        end else begin
            r_prev      <= n_prev;
            r_isum      <= n_isum;
            r_cnt       <= n_cnt;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
        r_temp    <= n_temp;
        r_err     <= n_err;
        r_derr    <= n_derr;
        r_prod    <= n_prod;
        r_gate    <= n_gate;
        r_acc     <= n_acc;
        r_duty    <= n_duty;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_div_cnt <= n_div_cnt;
        r_o_duty  <= n_o_duty;
        r_o_on    <= n_o_on;
        r_o_off   <= n_o_off;
        r_o_mode  <= n_o_mode;
        r_o_temp  <= n_o_temp;
    end

    assign o_stat.div_last = (r_div_cnt == bpid_pkg::DIV_CNT_W'(bpid_pkg::DIV_STEPS - 1));
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_valid         = r_out_valid;
    assign o_duty          = r_o_duty;
    assign o_on_ms         = r_o_on;
    assign o_off_ms        = r_o_off;
    assign o_fault_mode    = r_o_mode;
    assign o_temperature   = r_o_temp;

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_mode != bpid_pkg::MODE_NORMAL) |-> r_o_duty == '0)
        else $error("nonzero duty reported in a fault mode");

    a_times_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> bpid_pkg::MS_W'(r_o_on + r_o_off) == PERIOD_V[bpid_pkg::MS_W-1:0])
        else $error("on and off times do not add up to the period");

    a_duty_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_o_duty <= i_cfg.max_duty)
        else $error("duty above the configured ceiling");

endmodule

`default_nettype wire

// ----- dv/boiler_pid_duty_controller_test.sv -----
`timescale 1ns / 1ps

module boiler_pid_duty_controller_test;

    localparam longint PERIOD      = 1000;
    localparam int     LIMIT_CYCLES = 200000;
    localparam longint ISUM_HI     = (longint'(1) <<< 39) - 1;
    localparam longint ISUM_LO     = -(longint'(1) <<< 39);

    typedef struct {
        logic [bpid_pkg::DUTY_W-1:0] duty;
        logic [bpid_pkg::MS_W-1:0]   on_ms;
        logic [bpid_pkg::MS_W-1:0]   off_ms;
        logic [1:0]                  fault_mode;
        logic [bpid_pkg::TEMP_W-1:0] temperature;
    } t_drive_sample;

    class t_duty_scoreboard;
        longint target_temp, gain_p, gain_i, gain_d, max_duty, overheat_limit, sensor_floor;
        longint last_error, integ_sum, heat_count;
        bpid_pkg::t_mode mode;
        int     errors;
        t_drive_sample pending_drives[$];

        function new();
            target_temp    = bpid_pkg::RST_TARGET;
            gain_p         = bpid_pkg::RST_GAIN_P;
            gain_i         = bpid_pkg::RST_GAIN_I;
            gain_d         = bpid_pkg::RST_GAIN_D;
            max_duty       = bpid_pkg::RST_MAX;
            overheat_limit = bpid_pkg::RST_LIMIT;
            sensor_floor   = bpid_pkg::RST_FLOOR;
            last_error     = 0;
            integ_sum      = 0;
            heat_count     = 0;
            mode           = bpid_pkg::MODE_NORMAL;
            errors         = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void store_reg(bpid_pkg::t_cfg_idx idx,
                                logic [bpid_pkg::CFG_DAT_W-1:0] data);
            case (idx)
                bpid_pkg::CFG_TARGET: target_temp    = data[bpid_pkg::TEMP_W-1:0];
                bpid_pkg::CFG_GAIN_P: gain_p         = data;
                bpid_pkg::CFG_GAIN_I: gain_i         = data;
                bpid_pkg::CFG_GAIN_D: gain_d         = data;
                bpid_pkg::CFG_MAX:    max_duty       = data;
                bpid_pkg::CFG_LIMIT:  overheat_limit = data[bpid_pkg::LIMIT_W-1:0];
                bpid_pkg::CFG_FLOOR:  sensor_floor   = data[bpid_pkg::TEMP_W-1:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_drives.size();
        endfunction

        function void note_reading(logic [bpid_pkg::RAW_W-1:0] raw);
            longint temp, err, derr, ceil_v, sum, duty, on_t;
            t_drive_sample r;
            temp = raw[bpid_pkg::RAW_W-1:3];
            if (temp < sensor_floor) mode = bpid_pkg::MODE_SENSOR;
            if (temp > target_temp) begin
                if (heat_count > overheat_limit) mode = bpid_pkg::MODE_OVERHEAT;
                else if (heat_count < 255) heat_count++;
            end else if (mode == bpid_pkg::MODE_OVERHEAT) begin
                if (heat_count > 0) heat_count--;
                if (heat_count == 0) mode = bpid_pkg::MODE_NORMAL;
            end
            err = target_temp - temp;
            derr = err - last_error;
            last_error = err;
            ceil_v = max_duty <<< bpid_pkg::FRAC_W;
            if (integ_sum < ceil_v) begin
                integ_sum = integ_sum + gain_i * err;
                if (integ_sum > ISUM_HI) integ_sum = ISUM_HI;
                if (integ_sum < ISUM_LO) integ_sum = ISUM_LO;
            end
            sum = gain_p * err + integ_sum + gain_d * derr;
            if (sum > ceil_v) sum = ceil_v;
            if (sum < 0) sum = 0;
            duty = sum >>> bpid_pkg::FRAC_W;
            if (mode != bpid_pkg::MODE_NORMAL) duty = 0;
            on_t = (max_duty == 0) ? 0 : (duty * PERIOD) / max_duty;
            r.duty        = duty[bpid_pkg::DUTY_W-1:0];
            r.on_ms       = on_t[bpid_pkg::MS_W-1:0];
            r.off_ms      = 10'(PERIOD - on_t);
            r.fault_mode  = mode;
            r.temperature = temp[bpid_pkg::TEMP_W-1:0];
            pending_drives.push_back(r);
        endfunction

        task check_drive(t_drive_sample got);
            t_drive_sample exp_r;
            if (pending_drives.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            exp_r = pending_drives.pop_front();
            if (got.duty !== exp_r.duty)
                report($sformatf("duty %0d, expected %0d", got.duty, exp_r.duty));
            if (got.on_ms !== exp_r.on_ms)
                report($sformatf("on_ms %0d, expected %0d", got.on_ms, exp_r.on_ms));
            if (got.off_ms !== exp_r.off_ms)
                report($sformatf("off_ms %0d, expected %0d", got.off_ms, exp_r.off_ms));
            if (got.fault_mode !== exp_r.fault_mode)
                report($sformatf("fault_mode %0d, expected %0d",
                                 got.fault_mode, exp_r.fault_mode));
            if (got.temperature !== exp_r.temperature)
                report($sformatf("temperature %0d, expected %0d",
                                 got.temperature, exp_r.temperature));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    bpid_in_if  in_if ();
    bpid_out_if out_if ();
    bpid_cfg_if cfg_if ();

    boiler_pid_duty_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_duty_scoreboard board;
    int  src_idle_pct;
    int  sink_idle_pct;
    bit  long_stall_req;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int hold;
        hold = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                out_if.ready = 1'b0;
            end else begin
                out_if.ready = ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        t_drive_sample got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.duty        = out_if.duty;
                got.on_ms       = out_if.on_ms;
                got.off_ms      = out_if.off_ms;
                got.fault_mode  = out_if.fault_mode;
                got.temperature = out_if.temperature;
                board.check_drive(got);
            end
        end
    end

    task automatic send_raw(input logic [bpid_pkg::RAW_W-1:0] raw);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid    = 1'b1;
        in_if.raw_word = raw;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_reading(raw);
    endtask

    task automatic wait_until_settled();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (board.outstanding() > 0) @(posedge i_clk);
    endtask

    task automatic program_reg(input bpid_pkg::t_cfg_idx idx,
                               input logic [bpid_pkg::CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        do @(posedge i_clk); while (!cfg_if.ready);
        board.store_reg(idx, data);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic int pick(int lo, int hi, int mid_hi);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return $urandom_range(lo, mid_hi);
    endfunction

    function automatic logic [bpid_pkg::CFG_DAT_W-1:0] with_noise(int v, int w);
        logic [bpid_pkg::CFG_DAT_W-1:0] n;
        n = $urandom;
        n = n << w;
        return n | v[bpid_pkg::CFG_DAT_W-1:0];
    endfunction

    initial begin
        int ph, k, r, walk, tgt, flr;
        logic [bpid_pkg::RAW_W-1:0] raw;

        board = new();
        src_idle_pct   = 37;
        sink_idle_pct  = 55;
        long_stall_req = 1'b0;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.raw_word = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = bpid_pkg::CFG_TARGET;
        cfg_if.data    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: on target, below target, then a sticky sensor fault.
        send_raw(16'h0BE0);
        send_raw(16'h0A05);
        send_raw(16'h0000);
        send_raw(16'h0A07);

        // An overheat episode replaces the sensor fault, then cooling clears it.
        wait_until_settled();
        program_reg(bpid_pkg::CFG_LIMIT, 16'hFF00);
        program_reg(bpid_pkg::CFG_GAIN_I, 16'd64);
        program_reg(bpid_pkg::CFG_GAIN_D, 16'd128);
        send_raw(16'h0C80);
        send_raw(16'h0C80);
        send_raw(16'hFFFF);
        send_raw(16'h0BE0);
        send_raw(16'h0148);
        send_raw(16'h0140);

        // Every register but the floor at its top value, the floor at zero; the integral stops past the ceiling.
        wait_until_settled();
        program_reg(bpid_pkg::CFG_TARGET, 16'hFFFF);
        program_reg(bpid_pkg::CFG_GAIN_P, 16'hFFFF);
        program_reg(bpid_pkg::CFG_GAIN_I, 16'hFFFF);
        program_reg(bpid_pkg::CFG_GAIN_D, 16'hFFFF);
        program_reg(bpid_pkg::CFG_MAX, 16'hFFFF);
        program_reg(bpid_pkg::CFG_LIMIT, 16'h00FF);
        program_reg(bpid_pkg::CFG_FLOOR, 16'hE000);
        send_raw(16'h0000);
        send_raw(16'h0007);
        send_raw(16'hFFF8);
        send_raw(16'h8000);

        wait_until_settled();
        program_reg(bpid_pkg::CFG_TARGET, 16'hE000);
        program_reg(bpid_pkg::CFG_GAIN_P, 16'h0000);
        program_reg(bpid_pkg::CFG_GAIN_D, 16'h0000);
        send_raw(16'h0008);
        send_raw(16'h0000);

        // A zero full-scale duty gives zero on-time.
        wait_until_settled();
        program_reg(bpid_pkg::CFG_MAX, 16'h0000);
        program_reg(bpid_pkg::CFG_TARGET, 16'd380);
        program_reg(bpid_pkg::CFG_GAIN_P, 16'd256);
        send_raw(16'h0A00);
        send_raw(16'hFFFF);

        wait_until_settled();
        program_reg(bpid_pkg::CFG_FLOOR, 16'h1FFF);
        program_reg(bpid_pkg::CFG_MAX, 16'd1);
        send_raw(16'hFFF8);
        send_raw(16'hFFF0);

        for (ph = 0; ph < 6; ph++) begin
            src_idle_pct  = (ph < 2) ? 37 : (ph < 4) ? 55 : 0;
            sink_idle_pct = (ph < 2) ? 55 : (ph < 4) ? 37 : 0;
            wait_until_settled();
            tgt = pick(0, 8191, 7000);
            flr = pick(0, 8191, tgt);
            program_reg(bpid_pkg::CFG_TARGET, with_noise(tgt, bpid_pkg::TEMP_W));
            program_reg(bpid_pkg::CFG_GAIN_P, 16'(pick(0, 65535, 2048)));
            program_reg(bpid_pkg::CFG_GAIN_I, 16'(pick(0, 65535, 256)));
            program_reg(bpid_pkg::CFG_GAIN_D, 16'(pick(0, 65535, 1024)));
            program_reg(bpid_pkg::CFG_MAX, 16'(pick(1, 65535, 10000)));
            program_reg(bpid_pkg::CFG_LIMIT,
                        with_noise(pick(0, 255, 20), bpid_pkg::LIMIT_W));
            program_reg(bpid_pkg::CFG_FLOOR, with_noise(flr, bpid_pkg::TEMP_W));
            walk = tgt;
            for (k = 0; k < 75; k++) begin
                if (ph == 0 && k == 30) long_stall_req = 1'b1;
                if (ph == 1 && k == 40) wait_until_settled();
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    raw = $urandom;
                end else if (r < 12 && flr > 0) begin
                    raw = {13'($urandom_range(0, flr - 1)), 3'($urandom)};
                end else begin
                    walk += $urandom_range(0, 24) - 12;
                    if (walk > tgt + 60) walk -= 20;
                    if (walk < tgt - 60) walk += 20;
                    if (walk < 0) walk = 0;
                    if (walk > 8191) walk = 8191;
                    raw = {walk[bpid_pkg::TEMP_W-1:0], 3'($urandom)};
                end
                send_raw(raw);
            end
        end

        wait_until_settled();
        repeat (40) @(posedge i_clk);
        if (board.outstanding() > 0)
            board.report($sformatf("%0d results never arrived", board.outstanding()));
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
